// File: rtl/srbs_pkg.sv
// shared types and constants for the sensor reading band statistics block
package srbs_pkg;

  localparam int LEVEL_W   = 15;
  localparam int READING_W = 16;
  localparam int COUNT_W   = 9;
  localparam int SUM_W     = 24;
  localparam int INDEX_W   = 8;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [LEVEL_W-1:0] WARNING_RESET  = 15'd480;
  localparam logic [LEVEL_W-1:0] CRITICAL_RESET = 15'd720;
  localparam logic [LEVEL_W-1:0] SHUTDOWN_RESET = 15'd960;

  localparam logic signed [READING_W-1:0] MIN_START = 16'sd32767;
  localparam logic signed [READING_W-1:0] MAX_START = 16'sd0;

  localparam logic signed [SUM_W-1:0] SUM_POS_LIMIT = 24'sh7FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_NEG_LIMIT = 24'sh800000;

  typedef enum logic [1:0] {
    REG_WARNING  = 2'd0,
    REG_CRITICAL = 2'd1,
    REG_SHUTDOWN = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    BAND_NORMAL   = 3'd0,
    BAND_WARNING  = 3'd1,
    BAND_CRITICAL = 3'd2,
    BAND_SHUTDOWN = 3'd3,
    BAND_SKIPPED  = 3'd4
  } band_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] warning_level;
    logic [LEVEL_W-1:0] critical_level;
    logic [LEVEL_W-1:0] shutdown_level;
  } levels_t;

  typedef struct packed {
    band_t band;
    logic  crit_hit;
  } class_t;

  typedef struct packed {
    band_t                       band;
    logic [COUNT_W-1:0]          valid_count;
    logic [COUNT_W-1:0]          skipped_count;
    logic [COUNT_W-1:0]          normal_count;
    logic [COUNT_W-1:0]          warning_count;
    logic [COUNT_W-1:0]          critical_count;
    logic [COUNT_W-1:0]          shutdown_count;
    logic signed [READING_W-1:0] lowest;
    logic signed [READING_W-1:0] highest;
    logic signed [SUM_W-1:0]     sum;
    logic [INDEX_W-1:0]          first_critical_index;
    logic                        first_critical_seen;
  } result_t;

endpackage

// File: rtl/srbs_regs.sv
// apb threshold registers
module srbs_regs
  import srbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output levels_t           levels
);

  reg_index_t idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels.warning_level  <= WARNING_RESET;
      levels.critical_level <= CRITICAL_RESET;
      levels.shutdown_level <= SHUTDOWN_RESET;
    end else if (wr) begin
      case (idx)
        REG_WARNING:  levels.warning_level  <= pwdata[LEVEL_W-1:0];
        REG_CRITICAL: levels.critical_level <= pwdata[LEVEL_W-1:0];
        REG_SHUTDOWN: levels.shutdown_level <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WARNING:  prdata = APB_DW'(levels.warning_level);
      REG_CRITICAL: prdata = APB_DW'(levels.critical_level);
      REG_SHUTDOWN: prdata = APB_DW'(levels.shutdown_level);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: rtl/srbs_classify.sv
// band classifier and first-critical trigger
module srbs_classify
  import srbs_pkg::*;
(
  input  logic signed [READING_W-1:0] reading,
  input  levels_t                     levels,
  output class_t                      cls
);

  logic signed [READING_W:0] r_ext;
  logic signed [READING_W:0] warn_ext;
  logic signed [READING_W:0] crit_ext;
  logic signed [READING_W:0] shut_ext;

  assign r_ext    = {reading[READING_W-1], reading};
  assign warn_ext = $signed({2'b00, levels.warning_level});
  assign crit_ext = $signed({2'b00, levels.critical_level});
  assign shut_ext = $signed({2'b00, levels.shutdown_level});

  always_comb begin
    cls.crit_hit = (r_ext >= crit_ext);
    priority if (reading == '0) begin
      cls.band = BAND_SKIPPED;
    end else if (r_ext >= shut_ext) begin
      cls.band = BAND_SHUTDOWN;
    end else if (r_ext >= crit_ext) begin
      cls.band = BAND_CRITICAL;
    end else if (r_ext >= warn_ext) begin
      cls.band = BAND_WARNING;
    end else begin
      cls.band = BAND_NORMAL;
    end
  end

endmodule

// File: rtl/srbs_stats.sv
// batch statistics state and update logic
module srbs_stats
  import srbs_pkg::*;
#(
  parameter int BATCH_SIZE = 256
)
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic signed [READING_W-1:0] reading,
  input  logic                        last,
  input  class_t                      cls,
  output result_t                     result
);

  localparam int CW = $clog2(BATCH_SIZE + 1);
  localparam int OW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int PW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] CAP    = CW'(BATCH_SIZE);
  localparam logic [CW-1:0] CAP_M1 = CW'(BATCH_SIZE - 1);

  logic [CW-1:0] valid_tally, skipped_tally, normal_tally;
  logic [CW-1:0] warning_tally, critical_tally, shutdown_tally;
  logic [CW-1:0] valid_tally_next, skipped_tally_next, normal_tally_next;
  logic [CW-1:0] warning_tally_next, critical_tally_next, shutdown_tally_next;
  logic signed [READING_W-1:0] running_min, running_max;
  logic signed [READING_W-1:0] running_min_next, running_max_next;
  logic signed [SUM_W-1:0]     running_sum, running_sum_next;
  logic [CW-1:0]               position, position_next;
  logic [INDEX_W-1:0]          first_index, first_index_next;
  logic                        first_found, first_found_next;

  logic                        is_valid;
  logic [CW-1:0]               pos_sat;
  logic [PW-1:0]               pos_ext;
  logic signed [SUM_W:0]       sum_wide;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] t, input logic en);
    logic [CW-1:0] r;
    r = t;
    if (en && (t < CAP)) r = t + 1'b1;
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] t);
    logic [OW-1:0] w;
    w = OW'(t);
    return w[COUNT_W-1:0];
  endfunction

  assign is_valid = (cls.band != BAND_SKIPPED);
  assign pos_sat  = (position > CAP_M1) ? CAP_M1 : position;
  assign pos_ext  = PW'(pos_sat);
  assign sum_wide = {running_sum[SUM_W-1], running_sum}
                  + {{(SUM_W + 1 - READING_W){reading[READING_W-1]}}, reading};

  always_comb begin
    valid_tally_next    = bump(valid_tally, is_valid);
    skipped_tally_next  = bump(skipped_tally, !is_valid);
    normal_tally_next   = bump(normal_tally, cls.band == BAND_NORMAL);
    warning_tally_next  = bump(warning_tally, cls.band == BAND_WARNING);
    critical_tally_next = bump(critical_tally, cls.band == BAND_CRITICAL);
    shutdown_tally_next = bump(shutdown_tally, cls.band == BAND_SHUTDOWN);
    position_next       = bump(position, 1'b1);

    running_min_next = running_min;
    running_max_next = running_max;
    running_sum_next = running_sum;
    if (is_valid) begin
      if (reading < running_min) running_min_next = reading;
      if (reading > running_max) running_max_next = reading;
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
        running_sum_next = sum_wide[SUM_W] ? SUM_NEG_LIMIT : SUM_POS_LIMIT;
      end else begin
        running_sum_next = sum_wide[SUM_W-1:0];
      end
    end

    first_found_next = first_found | cls.crit_hit;
    first_index_next = (!first_found && cls.crit_hit) ? pos_ext[INDEX_W-1:0] : first_index;
  end

  always_comb begin
    result.band                 = cls.band;
    result.valid_count          = to_count(valid_tally_next);
    result.skipped_count        = to_count(skipped_tally_next);
    result.normal_count         = to_count(normal_tally_next);
    result.warning_count        = to_count(warning_tally_next);
    result.critical_count       = to_count(critical_tally_next);
    result.shutdown_count       = to_count(shutdown_tally_next);
    result.lowest               = running_min_next;
    result.highest              = running_max_next;
    result.sum                  = running_sum_next;
    result.first_critical_index = first_index_next;
    result.first_critical_seen  = first_found_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      valid_tally    <= '0;
      skipped_tally  <= '0;
      normal_tally   <= '0;
      warning_tally  <= '0;
      critical_tally <= '0;
      shutdown_tally <= '0;
      running_min    <= MIN_START;
      running_max    <= MAX_START;
      running_sum    <= '0;
      position       <= '0;
      first_index    <= '0;
      first_found    <= 1'b0;
    end else if (step) begin
      valid_tally    <= valid_tally_next;
      skipped_tally  <= skipped_tally_next;
      normal_tally   <= normal_tally_next;
      warning_tally  <= warning_tally_next;
      critical_tally <= critical_tally_next;
      shutdown_tally <= shutdown_tally_next;
      running_min    <= running_min_next;
      running_max    <= running_max_next;
      running_sum    <= running_sum_next;
      position       <= position_next;
      first_index    <= first_index_next;
      first_found    <= first_found_next;
    end
  end

endmodule

// File: rtl/sensor_reading_band_statistics.sv
// top level: temperature band statistics over batches of sensor readings
//
// slave stream: s_tdata carries one signed q11.4 reading, s_tlast marks the
// final reading of a batch. master stream: one result per reading with the
// band and the running batch statistics packed into m_tdata.
// thresholds sit in three apb registers (warning 0x0, critical 0x4,
// shutdown 0x8); write them only while no transfer is in flight.
// a reading accepted on the slave side passes through the input register,
// then the result register, before its result shows on the master side.
// throughput: one reading per cycle unless the receiver stalls; the
// statistics update is one add with saturation and a few compares between
// the two registers. when the receiver stalls the result register holds and
// the input register fills, after which s_tready drops; no transfer is lost.
// after a reading with s_tlast the statistics return to their start values.
// reset clears both stream registers, the statistics and the thresholds
// (480, 720, 960 sixteenths of a degree); s_tready is high right after it.
module sensor_reading_band_statistics
  import srbs_pkg::*;
#(
  parameter int BATCH_SIZE = 256
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // reading[15:0]
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  // band[2:0] valid_count[11:3] skipped_count[20:12] normal_count[29:21]
  // warning_count[38:30] critical_count[47:39] shutdown_count[56:48]
  // lowest[72:57] highest[88:73] sum[112:89] first_critical_index[120:113]
  // first_critical_seen[121] zero[127:122]
  output logic [127:0]      m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  levels_t                     levels;
  class_t                      cls;
  result_t                     result;
  result_t                     out_result;
  logic                        in_valid;
  logic signed [READING_W-1:0] in_reading;
  logic                        in_last;
  logic                        out_valid;
  logic                        advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  srbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .levels  (levels)
  );

  srbs_classify u_classify (
    .reading (in_reading),
    .levels  (levels),
    .cls     (cls)
  );

  srbs_stats #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_stats (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .reading (in_reading),
    .last    (in_last),
    .cls     (cls),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_reading <= $signed(s_tdata);
      in_last    <= s_tlast;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0,
                     out_result.first_critical_seen,
                     out_result.first_critical_index,
                     out_result.sum,
                     out_result.highest,
                     out_result.lowest,
                     out_result.shutdown_count,
                     out_result.critical_count,
                     out_result.warning_count,
                     out_result.normal_count,
                     out_result.skipped_count,
                     out_result.valid_count,
                     out_result.band};

endmodule
